>>> sv/ps2mt_pkg.sv
// Package with the packet phase type, register indexes and constants of the PS/2 packet tracker.
`timescale 1ns / 1ps

package ps2mt_pkg;

    // Packet phase: which byte of a three-byte packet is expected next
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1
    } reg_index_t;

    localparam int unsigned CFG_W = 13;

    localparam logic [7:0] FIRST_BYTE_MARK = 8'h08;
    localparam logic [2:0] BUTTON_MASK     = 3'h7;

    localparam int unsigned WIDTH_RESET  = 320;
    localparam int unsigned HEIGHT_RESET = 200;
    localparam int unsigned COL_RESET    = 160;
    localparam int unsigned ROW_RESET    = 100;

endpackage

>>> sv/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: packet assembly, cursor update and clamping.
`timescale 1ns / 1ps

// Takes one received mouse byte per transaction and assembles three-byte packets;
// a first byte without bit 3 set is dropped. On the third byte the cursor moves by
// the signed deltas in bytes 1 and 2 (row moves opposite to the reported dy), is
// clamped to the configured screen (a size of zero acts as one) and one result
// transaction carries position, buttons and deltas. A byte is accepted every cycle
// unless the output register is full and not being taken; the packet state and
// cursor update in the accepting cycle and the result appears in the output
// register in the cycle after. Screen size writes take effect at the next
// packet's clamp and should be made while no byte is in flight.
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [ps2mt_pkg::CFG_W-1:0]  cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COORD_BITS-1:0]        cursor_col,
    output logic [COORD_BITS-1:0]        cursor_row,
    output logic [2:0]                   button_bits,
    output logic signed [7:0]            delta_col,
    output logic signed [7:0]            delta_row
);

    localparam int CW = ps2mt_pkg::CFG_W;
    // Signed working width for sums and limits
    localparam int EW = ((COORD_BITS > CW) ? COORD_BITS : CW) + 2;
    localparam logic signed [EW-1:0] COORD_TOP = EW'((64'd1 << COORD_BITS) - 64'd1);

    ps2mt_pkg::phase_t       phase_reg, phase_next;
    logic [2:0]              buttons_reg, buttons_next;
    logic [7:0]              dx_reg, dx_next;
    logic [COORD_BITS-1:0]   col_reg, col_next;
    logic [COORD_BITS-1:0]   row_reg, row_next;
    logic [CW-1:0]           width_reg, height_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]   out_col_reg, out_row_reg;
    logic [2:0]              out_buttons_reg;
    logic [7:0]              out_dx_reg, out_dy_reg;

    logic                    in_accept;
    logic                    emit;
    logic signed [7:0]       dx_s, dy_s;
    logic [CW-1:0]           width_lim, height_lim;
    logic signed [EW-1:0]    col_sum, row_sum, col_lim, row_lim, col_clamp, row_clamp;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign cursor_col  = out_col_reg;
    assign cursor_row  = out_row_reg;
    assign button_bits = out_buttons_reg;
    assign delta_col   = $signed(out_dx_reg);
    assign delta_row   = $signed(out_dy_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(ps2mt_pkg::WIDTH_RESET);
            height_reg <= CW'(ps2mt_pkg::HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ps2mt_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                ps2mt_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor arithmetic: move, then clamp to [0, limit]
    always_comb
    begin
        dx_s = $signed(dx_reg);
        dy_s = $signed(rx_byte);

        col_sum = $signed({{(EW-COORD_BITS){1'b0}}, col_reg}) + EW'(dx_s);
        row_sum = $signed({{(EW-COORD_BITS){1'b0}}, row_reg}) - EW'(dy_s);

        width_lim  = (width_reg == '0)  ? '0 : width_reg - CW'(1);
        height_lim = (height_reg == '0) ? '0 : height_reg - CW'(1);
        col_lim = $signed({{(EW-CW){1'b0}}, width_lim});
        row_lim = $signed({{(EW-CW){1'b0}}, height_lim});
        if (col_lim > COORD_TOP)
            col_lim = COORD_TOP;
        if (row_lim > COORD_TOP)
            row_lim = COORD_TOP;

        if (col_sum < 0)
            col_clamp = '0;
        else if (col_sum > col_lim)
            col_clamp = col_lim;
        else
            col_clamp = col_sum;

        if (row_sum < 0)
            row_clamp = '0;
        else if (row_sum > row_lim)
            row_clamp = row_lim;
        else
            row_clamp = row_sum;
    end

    // Packet phase: next state and packet state updates
    always_comb
    begin
        phase_next   = phase_reg;
        buttons_next = buttons_reg;
        dx_next      = dx_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        emit         = 1'b0;
        if (in_accept)
        begin
            unique case (phase_reg)
                ps2mt_pkg::PH_DX:
                begin
                    dx_next    = rx_byte;
                    phase_next = ps2mt_pkg::PH_DY;
                end
                ps2mt_pkg::PH_DY:
                begin
                    phase_next = ps2mt_pkg::PH_FIRST;
                    col_next   = col_clamp[COORD_BITS-1:0];
                    row_next   = row_clamp[COORD_BITS-1:0];
                    emit       = 1'b1;
                end
                default:
                begin
                    if ((rx_byte & ps2mt_pkg::FIRST_BYTE_MARK) != 8'h00)
                    begin
                        buttons_next = rx_byte[2:0] & ps2mt_pkg::BUTTON_MASK;
                        phase_next   = ps2mt_pkg::PH_DX;
                    end
                    else
                        phase_next = ps2mt_pkg::PH_FIRST;
                end
            endcase
        end
    end

    // Packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ps2mt_pkg::PH_FIRST;
            buttons_reg <= '0;
            dx_reg      <= '0;
            col_reg     <= COORD_BITS'(ps2mt_pkg::COL_RESET);
            row_reg     <= COORD_BITS'(ps2mt_pkg::ROW_RESET);
        end
        else
        begin
            phase_reg   <= phase_next;
            buttons_reg <= buttons_next;
            dx_reg      <= dx_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // Output register valid
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output payload, loaded when a packet completes
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_col_reg     <= col_next;
            out_row_reg     <= row_next;
            out_buttons_reg <= buttons_reg;
            out_dx_reg      <= dx_reg;
            out_dy_reg      <= rx_byte;
        end
    end

endmodule

>>> sim/tb.sv
// Self-checking testbench for the PS/2 mouse packet tracker.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS   = 12;
    localparam int CFG_W        = ps2mt_pkg::CFG_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int WATCHDOG_MAX = 4000;
    localparam int REPORT_MAX   = 10;

    // Indexes that map to no register
    localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [2:0]            buttons;
        logic signed [7:0]     dcol;
        logic signed [7:0]     drow;
    } cursor_report_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [7:0]            rx_byte     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [COORD_BITS-1:0] cursor_col;
    logic [COORD_BITS-1:0] cursor_row;
    logic [2:0]            button_bits;
    logic signed [7:0]     delta_col;
    logic signed [7:0]     delta_row;

    // Tracker state mirrored by the testbench
    ps2mt_pkg::phase_t     exp_phase   = ps2mt_pkg::PH_FIRST;
    logic [2:0]            exp_buttons = '0;
    logic [7:0]            exp_dx      = '0;
    logic [COORD_BITS-1:0] exp_col     = COORD_BITS'(ps2mt_pkg::COL_RESET);
    logic [COORD_BITS-1:0] exp_row     = COORD_BITS'(ps2mt_pkg::ROW_RESET);
    logic [CFG_W-1:0]      exp_width   = CFG_W'(ps2mt_pkg::WIDTH_RESET);
    logic [CFG_W-1:0]      exp_height  = CFG_W'(ps2mt_pkg::HEIGHT_RESET);

    cursor_report_t pending_reports[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    bit  done          = 1'b0;

    ps2_mouse_packet_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .button_bits (button_bits),
        .delta_col   (delta_col),
        .delta_row   (delta_row)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp one axis to [0, size - 1]; size 0 acts as 1, limit saturates at the coord range
    function automatic logic [COORD_BITS-1:0] clamp_axis(input int v,
                                                         input logic [CFG_W-1:0] size);
        int lim;
        lim = (size == 0) ? 0 : int'(size) - 1;
        if (lim > (1 << COORD_BITS) - 1)
            lim = (1 << COORD_BITS) - 1;
        if (v < 0)
            return '0;
        if (v > lim)
            return lim[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // Advance the mirrored tracker by one accepted byte; queue a report on packet end
    task automatic track_byte(input logic [7:0] b);
        cursor_report_t rpt;
        int             next_col;
        int             next_row;
        case (exp_phase)
            ps2mt_pkg::PH_DX:
            begin
                exp_dx    = b;
                exp_phase = ps2mt_pkg::PH_DY;
            end
            ps2mt_pkg::PH_DY:
            begin
                exp_phase = ps2mt_pkg::PH_FIRST;
                next_col  = int'(exp_col) + int'($signed(exp_dx));
                next_row  = int'(exp_row) - int'($signed(b));
                exp_col   = clamp_axis(next_col, exp_width);
                exp_row   = clamp_axis(next_row, exp_height);
                rpt.col     = exp_col;
                rpt.row     = exp_row;
                rpt.buttons = exp_buttons;
                rpt.dcol    = exp_dx;
                rpt.drow    = b;
                pending_reports.push_back(rpt);
            end
            default:
            begin
                if ((b & ps2mt_pkg::FIRST_BYTE_MARK) != 0)
                begin
                    exp_buttons = b[2:0] & ps2mt_pkg::BUTTON_MASK;
                    exp_phase   = ps2mt_pkg::PH_DX;
                end
                else
                begin
                    exp_phase = ps2mt_pkg::PH_FIRST;
                end
            end
        endcase
    endtask

    // Offer one byte, idling the requested share of cycles first, and wait for the transaction
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        track_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] first, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(first);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Register write; cfg_valid is left high so back-to-back writes stay continuous
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ps2mt_pkg::REG_SCREEN_WIDTH:  exp_width  = data;
            ps2mt_pkg::REG_SCREEN_HEIGHT: exp_height = data;
            default: ;
        endcase
    endtask

    task automatic write_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(ps2mt_pkg::REG_SCREEN_WIDTH, w);
        write_reg(ps2mt_pkg::REG_SCREEN_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every queued report plus the pipeline tail
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] random_screen_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(4096, 8191));
            3, 4:    return CFG_W'($urandom_range(1, 16));
            default: return CFG_W'($urandom_range(17, 700));
        endcase
    endfunction

    // Mostly well-formed packets, some stray bytes that break the framing
    task automatic run_random_bytes(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_packet(8'($urandom_range(255)) | ps2mt_pkg::FIRST_BYTE_MARK,
                            8'($urandom_range(255)), 8'($urandom_range(255)));
                sent += 3;
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // Reset config: dropped first bytes, delta extremes, clamping on the right, top and bottom edges
    task automatic test_directed_packets();
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'h0F, 8'h80, 8'h7F);
        send_packet(8'hFF, 8'h7F, 8'h80);
        send_packet(8'h09, 8'h7F, 8'h80);
        send_packet(8'h0A, 8'h80, 8'h7F);
        send_packet(8'h0C, 8'h80, 8'h7F);
        send_packet(8'h0B, 8'h00, 8'h00);
        drain_reports();
    endtask

    // Zero size, oversized screens driven to saturation and back to zero, and the one-pixel screen
    task automatic test_screen_extremes();
        write_screen('0, '0);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'h0D, 8'h80, 8'h7F);
        send_packet(8'h0E, 8'h01, 8'hFF);
        drain_reports();
        write_screen('1, CFG_W'(4096));
        repeat (35) send_packet(8'h09, 8'h7F, 8'h80);
        drain_reports();
        write_screen(CFG_W'(4096), '1);
        repeat (35) send_packet(8'h0A, 8'h80, 8'h7F);
        drain_reports();
        write_screen(CFG_W'(1), CFG_W'(1));
        send_packet(8'h0F, 8'h40, 8'hC0);
        send_packet(8'h08, 8'hC0, 8'h40);
        drain_reports();
    endtask

    // Writes to unmapped indexes must leave the screen size alone
    task automatic test_unmapped_index();
        write_reg(ps2mt_pkg::REG_SCREEN_WIDTH, CFG_W'(64));
        write_reg(ps2mt_pkg::REG_SCREEN_HEIGHT, CFG_W'(48));
        write_reg(REG_UNMAPPED_A, '1);
        write_reg(REG_UNMAPPED_B, '0);
        cfg_valid <= 1'b0;
        send_packet(8'h09, 8'h7F, 8'h80);
        send_packet(8'h0A, 8'h80, 8'h7F);
        send_packet(8'h0B, 8'h7F, 8'h7F);
        drain_reports();
    endtask

    // Long receiver hold while bytes keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (20)
            send_packet(8'($urandom_range(255)) | ps2mt_pkg::FIRST_BYTE_MARK,
                        8'($urandom_range(255)), 8'($urandom_range(255)));
        drain_reports();
        send_idle_pct = saved_pct;
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3)
        begin
            write_screen(random_screen_size(), random_screen_size());
            run_random_bytes(180);
            drain_reports();
        end
    endtask

    // Receiver: random stalls, or a long counted hold when requested
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest queued report
    always @(posedge clk)
    begin : check_reports
        cursor_report_t got;
        cursor_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {cursor_col, cursor_row, button_bits, delta_col, delta_row};
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected report: col %0d row %0d btn %0d dcol %0d drow %0d",
                             got.col, got.row, got.buttons, got.dcol, got.drow);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.col !== want.col || got.row !== want.row ||
                    got.buttons !== want.buttons || got.dcol !== want.dcol ||
                    got.drow !== want.drow)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("report mismatch: exp col %0d row %0d btn %0d",
                                 want.col, want.row, want.buttons,
                                 " dcol %0d drow %0d,", want.dcol, want.drow,
                                 " got col %0d row %0d btn %0d",
                                 got.col, got.row, got.buttons,
                                 " dcol %0d drow %0d", got.dcol, got.drow);
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (!done)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 55;
        test_directed_packets();
        test_screen_extremes();
        test_unmapped_index();
        test_output_backpressure();
        test_random_traffic(17, 55);
        test_random_traffic(55, 17);
        test_random_traffic(0, 0);

        drain_reports();
        repeat (10) @(posedge clk);
        done = 1'b1;
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
